// ----- hdl/dvp_pkg.sv -----
// Shared types and constants for the dotted version parser.
// No dependencies; imported by dvp_core and dotted_version_parser.
`default_nettype none

package dvp_pkg;

  // Character codes the parser recognizes
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  // Dot count at which no further field is started
  localparam logic [1:0] DOTS_FIELDS = 2'd2;
  localparam logic [1:0] DOTS_MAX    = 2'd3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_BAD      = 2'd3
  } dvp_status_t;

  // One input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } dvp_item_t;

endpackage

`default_nettype wire

// ----- hdl/dvp_core.sv -----
// Parser state and per-byte update for the dotted version parser.
// Depends on dvp_pkg for character codes, status codes and the word struct.
`default_nettype none

module dvp_core #(
  parameter int VALUE_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    step,
  input  dvp_pkg::dvp_item_t     item,
  output dvp_pkg::dvp_status_t   status,
  output logic [VALUE_BITS-1:0]  major_value,
  output logic [VALUE_BITS-1:0]  minor_value,
  output logic [VALUE_BITS-1:0]  patch_value
);
  import dvp_pkg::*;

  localparam int W = VALUE_BITS;

  // Parser state
  logic [1:0]   dots_seen,       dots_seen_next;
  logic [1:0]   field_index,     field_index_next;
  logic [W-1:0] accumulator,     accumulator_next;
  logic         field_has_digit, field_has_digit_next;
  logic [W-1:0] first_field,     first_field_next;
  logic [W-1:0] second_field,    second_field_next;
  logic         bad_format,      bad_format_next;
  logic         any_char_seen,   any_char_seen_next;

  // Multiply by ten as shift-add, plus the new digit
  logic [W+3:0] scaled;
  logic         overflow;
  logic         is_digit;
  logic         is_dot;

  assign scaled = ({4'b0, accumulator} << 3) + ({4'b0, accumulator} << 1)
                + {{W{1'b0}}, item.char_code[3:0]};
  assign overflow = |scaled[W+3:W];
  assign is_dot   = (item.char_code == CH_DOT);
  assign is_digit = item.char_code inside {[CH_ZERO:CH_NINE]};

  // Update state for one byte
  always_comb begin
    dots_seen_next       = dots_seen;
    field_index_next     = field_index;
    accumulator_next     = accumulator;
    field_has_digit_next = field_has_digit;
    first_field_next     = first_field;
    second_field_next    = second_field;
    bad_format_next      = bad_format;
    any_char_seen_next   = any_char_seen;
    if (item.has_char) begin
      any_char_seen_next = 1'b1;
      if (is_dot) begin
        if (dots_seen < DOTS_FIELDS) begin
          if (!field_has_digit) begin
            bad_format_next = 1'b1;
          end
          if (field_index == 2'd0) begin
            first_field_next = accumulator;
          end else begin
            second_field_next = accumulator;
          end
          field_index_next     = field_index + 2'd1;
          accumulator_next     = '0;
          field_has_digit_next = 1'b0;
        end
        if (dots_seen < DOTS_MAX) begin
          dots_seen_next = dots_seen + 2'd1;
        end
      end else if (is_digit) begin
        if (overflow) begin
          bad_format_next = 1'b1;
        end else begin
          accumulator_next     = scaled[W-1:0];
          field_has_digit_next = 1'b1;
        end
      end else begin
        bad_format_next = 1'b1;
      end
    end
  end

  // Classify the string as it stands after this byte
  always_comb begin
    if (!any_char_seen_next) begin
      status = ST_EMPTY;
    end else if (dots_seen_next > DOTS_FIELDS) begin
      status = ST_TOO_MANY;
    end else if (dots_seen_next < DOTS_FIELDS || !field_has_digit_next || bad_format_next) begin
      status = ST_BAD;
    end else begin
      status = ST_OK;
    end
  end

  // Zero the values unless the string is well formed
  assign major_value = (status == ST_OK) ? first_field_next  : '0;
  assign minor_value = (status == ST_OK) ? second_field_next : '0;
  assign patch_value = (status == ST_OK) ? accumulator_next  : '0;

  // Advance on each byte; drop back to reset at end of string
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      dots_seen       <= '0;
      field_index     <= '0;
      accumulator     <= '0;
      field_has_digit <= 1'b0;
      first_field     <= '0;
      second_field    <= '0;
      bad_format      <= 1'b0;
      any_char_seen   <= 1'b0;
    end else if (step) begin
      dots_seen       <= dots_seen_next;
      field_index     <= field_index_next;
      accumulator     <= accumulator_next;
      field_has_digit <= field_has_digit_next;
      first_field     <= first_field_next;
      second_field    <= second_field_next;
      bad_format      <= bad_format_next;
      any_char_seen   <= any_char_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dotted_version_parser.sv -----
// Top level of the dotted version parser: input register, parser core, result register.
// Depends on dvp_pkg and dvp_core.
//
// Usage:
//   Feed the version text one byte per word on the item channel
//   (char_code, has_char, last; item_valid / item_stall). A word with
//   has_char low carries no byte; with last high it just ends the string,
//   so an empty string reports status empty.
//   For each word with last high, one word appears on the result channel
//   (status, major_value, minor_value, patch_value; result_valid /
//   result_stall). Values are zero unless status is ok.
// Timing:
//   One byte per cycle sustained while item_stall is low. A word is held in
//   the input register, where the parser core updates its state with a single
//   multiply-by-ten shift-add and compare, and the result is registered:
//   result_valid rises once the last word steps out of the input register.
// Stall and reset:
//   While a result waits under result_stall, bytes that are not last keep
//   flowing; a second last word waits in the input register and
//   item_stall rises until the result is taken.
//   rst (synchronous) empties both registers and clears the parser state.
`default_nettype none

module dotted_version_parser #(
  parameter int VALUE_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire  [7:0]  char_code,
  input  wire         has_char,
  input  wire         last,
  input  wire         item_valid,
  output logic        item_stall,
  output logic [1:0]  status,
  output logic [31:0] major_value,
  output logic [31:0] minor_value,
  output logic [31:0] patch_value,
  output logic        result_valid,
  input  wire         result_stall
);
  import dvp_pkg::*;

  // Input register
  logic      held_valid;
  dvp_item_t held;

  // Core outputs
  dvp_status_t           core_status;
  logic [VALUE_BITS-1:0] core_major;
  logic [VALUE_BITS-1:0] core_minor;
  logic [VALUE_BITS-1:0] core_patch;

  logic block;
  logic step;
  logic emit;

  // Hold the last word while the previous result is still waiting
  assign block      = held_valid && held.last && result_valid && result_stall;
  assign item_stall = block;
  assign step       = held_valid && !block;
  assign emit       = step && held.last;

  // Load the input register whenever it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!block) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!block) begin
      held.char_code <= char_code;
      held.has_char  <= has_char;
      held.last      <= last;
    end
  end

  dvp_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (held),
    .status      (core_status),
    .major_value (core_major),
    .minor_value (core_minor),
    .patch_value (core_patch)
  );

  // Result register: refill when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= core_status;
      major_value <= 32'(core_major);
      minor_value <= 32'(core_minor);
      patch_value <= 32'(core_patch);
    end
  end

  // A new result only follows a last word that was stepped
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid && result_stall)) |-> $past(emit))
    else $error("result appeared without a last word");

  // The input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (held_valid && result_valid && result_stall))
    else $error("input stalled without a waiting result");

  // Values are zero on any status other than ok
  a_zero_values: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |->
      (major_value == 32'd0 && minor_value == 32'd0 && patch_value == 32'd0))
    else $error("nonzero value with a failing status");

  // A waiting result does not change
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    $past(result_valid && result_stall) |-> (result_valid && $stable(status)
      && $stable(major_value) && $stable(minor_value) && $stable(patch_value)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
